/* rtl/core/hbs_pkg.sv */
// Shared types, constants and helpers for the heap sort core.
package hbs_pkg;

    localparam int MAX_ITEMS = 2048;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int KEY_W     = 16;
    localparam int PAY_W     = 32;
    localparam int POS_W     = 11;
    localparam int ST_W      = 2;
    localparam int REC_W     = KEY_W + PAY_W;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic [CNT_W:0] idx_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [POS_W-1:0] position;
        logic             last;
        logic [ST_W-1:0]  status;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        rec_t              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // heap index 1..MAX_ITEMS maps onto RAM address 0..MAX_ITEMS-1
    function automatic logic [ADDR_W-1:0] to_addr(input idx_t idx);
        idx_t a;
        a = idx - idx_t'(1);
        return a[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/core/hbs_ram.sv */
// Generic simple dual-port RAM with registered read.
module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/hbs_engine.sv */
// Sift-up / sift-down sequencer working on the heap RAM.
module hbs_engine
    import hbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [KEY_W-1:0] s_key,
    input  logic [PAY_W-1:0] s_payload,
    output ram_req_t         ram_req,
    input  logic [REC_W-1:0] ram_rdata,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_XLAST  = 4'd1;
    localparam logic [3:0] S_XMOVE  = 4'd2;
    localparam logic [3:0] S_DNR    = 4'd3;
    localparam logic [3:0] S_DNCMP  = 4'd4;
    localparam logic [3:0] S_DNLONE = 4'd5;
    localparam logic [3:0] S_UPCMP  = 4'd6;
    localparam logic [3:0] S_PUT    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] j_reg, j_next;
    rec_t             cur_reg, cur_next;
    rec_t             left_reg, left_next;
    result_t          res_reg, res_next;
    logic             pend_reg, pend_next;

    rec_t             rd;
    idx_t             lj, rj;
    logic             take_r;
    logic [CNT_W-1:0] c_idx;
    logic [CNT_W-1:0] jd;
    idx_t             dn_l;
    idx_t             n_ext;
    logic [CNT_W-1:0] ja;
    logic [CNT_W-1:0] pj;

    assign rd     = rec_t'(ram_rdata);
    assign lj     = {j_reg, 1'b0};
    assign rj     = {j_reg, 1'b1};
    assign take_r = rd.key > left_reg.key;
    assign c_idx  = take_r ? rj[CNT_W-1:0] : lj[CNT_W-1:0];
    assign pj     = j_reg >> 1;
    assign n_ext  = {1'b0, count_reg};

    // node from which the next descent step starts
    always_comb begin
        if (state_reg == S_DNCMP) begin
            jd = c_idx;
        end else if (state_reg == S_XMOVE) begin
            jd = CNT_W'(1);
        end else begin
            jd = j_reg;
        end
    end
    assign dn_l = {jd, 1'b0};

    // node from which the next ascent step starts
    assign ja = (state_reg == S_IDLE) ? count_reg + CNT_W'(1) : pj;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        res_next      = res_reg;
        pend_next     = pend_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = to_addr({1'b0, j_reg});
        ram_req.wdata = cur_reg;
        ram_req.re    = 1'b0;
        ram_req.raddr = to_addr({1'b0, ja >> 1});
        res_valid     = 1'b0;

        unique case (state_reg) inside
            S_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_LOAD) begin
                        if (count_reg == CNT_W'(MAX_ITEMS)) begin
                            res_next   = '{key: '0, payload: '0, position: '0,
                                           last: 1'b0, status: ST_FULL};
                            pend_next  = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cur_next   = '{key: s_key, payload: s_payload};
                            count_next = ja;
                            j_next     = ja;
                            pend_next  = 1'b0;
                            if (ja > CNT_W'(1)) begin
                                ram_req.re = 1'b1;
                                state_next = S_UPCMP;
                            end else begin
                                state_next = S_PUT;
                            end
                        end
                    end else begin
                        pend_next = 1'b1;
                        if (count_reg == '0) begin
                            res_next   = '{key: '0, payload: '0, position: '0,
                                           last: 1'b0, status: ST_EMPTY};
                            state_next = S_FIN;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = to_addr(idx_t'(1));
                            state_next    = S_XLAST;
                        end
                    end
                end
            end

            S_XLAST: begin
                // root arrives; fetch the last record to move to the top
                res_next.key      = rd.key;
                res_next.payload  = rd.payload;
                res_next.position = POS_W'(count_reg - CNT_W'(1));
                res_next.last     = (count_reg == CNT_W'(1));
                res_next.status   = ST_OK;
                ram_req.re        = 1'b1;
                ram_req.raddr     = to_addr(n_ext);
                count_next        = count_reg - CNT_W'(1);
                state_next        = S_XMOVE;
            end

            S_XMOVE, S_DNCMP, S_DNR: begin
                if (state_reg == S_XMOVE) begin
                    cur_next = rd;
                    j_next   = CNT_W'(1);
                end
                if (state_reg == S_DNR) begin
                    left_next     = rd;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = to_addr(rj);
                    state_next    = S_DNCMP;
                end else if (state_reg == S_DNCMP &&
                             !(cur_reg.key < left_reg.key || cur_reg.key < rd.key)) begin
                    state_next = S_PUT;
                end else begin
                    if (state_reg == S_DNCMP) begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = take_r ? rd : left_reg;
                        j_next        = c_idx;
                    end
                    ram_req.raddr = to_addr(dn_l);
                    if (dn_l < n_ext) begin
                        ram_req.re = 1'b1;
                        state_next = S_DNR;
                    end else if (dn_l == n_ext) begin
                        ram_req.re = 1'b1;
                        state_next = S_DNLONE;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end

            S_DNLONE: begin
                // only a left child exists
                if (cur_reg.key < rd.key) begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = rd;
                    j_next        = lj[CNT_W-1:0];
                end
                state_next = S_PUT;
            end

            S_UPCMP: begin
                if (cur_reg.key > rd.key) begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = rd;
                    j_next        = pj;
                    if (pj > CNT_W'(1)) begin
                        ram_req.re = 1'b1;
                        state_next = S_UPCMP;
                    end else begin
                        state_next = S_PUT;
                    end
                end else begin
                    state_next = S_PUT;
                end
            end

            S_PUT: begin
                ram_req.we = 1'b1;
                state_next = S_FIN;
            end

            S_FIN: begin
                if (!pend_reg) begin
                    state_next = S_IDLE;
                end else begin
                    res_valid = 1'b1;
                    if (res_ready) begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        j_reg    <= j_next;
        cur_reg  <= cur_next;
        left_reg <= left_next;
        res_reg  <= res_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign res     = res_reg;

endmodule

/* rtl/core/hbs_out.sv */
// Result output register decoupling the sequencer from the consumer.
module hbs_out
    import hbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  result_t          res,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_out_key,
    output logic [PAY_W-1:0] m_out_payload,
    output logic [POS_W-1:0] m_position,
    output logic             m_last,
    output logic [ST_W-1:0]  m_status
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign res_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready) begin
            valid_next = res_valid;
            if (res_valid) begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_key     = data_reg.key;
    assign m_out_payload = data_reg.payload;
    assign m_position    = data_reg.position;
    assign m_last        = data_reg.last;
    assign m_status      = data_reg.status;

endmodule

/* rtl/core/binary_max_heap_sort_core.sv */
// Top level of the binary max-heap sort core.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, key, payload
//  m_      | out       | m_valid / m_ready  | out_key, out_payload, position, last, status
//
// One transaction at a time. A load walks L parent compares (up to 11); the next parent
// read overlaps the write-back of each compare.
// An extract walks D two-child levels (up to 10, one read per child), plus one more
// read for a lone left child.
// Synchronous active-low reset empties the heap; RAM contents are not cleared.
// A result waits in the output register; the engine stalls only while it is still full.
module binary_max_heap_sort_core
    import hbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [KEY_W-1:0] s_key,
    input  logic [PAY_W-1:0] s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_out_key,
    output logic [PAY_W-1:0] m_out_payload,
    output logic [POS_W-1:0] m_position,
    output logic             m_last,
    output logic [ST_W-1:0]  m_status
);

    ram_req_t         ram_req;
    logic [REC_W-1:0] ram_rdata;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    hbs_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_ITEMS)
    ) u_heap_ram (
        .clk   (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    hbs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_key     (s_key),
        .s_payload (s_payload),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    hbs_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_position    (m_position),
        .m_last        (m_last),
        .m_status      (m_status)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the binary max-heap sort core.
`timescale 1ns / 1ps

module tb;
    import hbs_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1_600_000;

    typedef enum logic [1:0] {RX_ALWAYS, RX_CHOPPY, RX_SLOW} rx_mode_t;
    typedef enum logic [1:0] {KEYS_WIDE, KEYS_NARROW, KEYS_EDGE} key_style_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_action;
    logic [KEY_W-1:0] s_key;
    logic [PAY_W-1:0] s_payload;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [KEY_W-1:0] m_out_key;
    logic [PAY_W-1:0] m_out_payload;
    logic [POS_W-1:0] m_position;
    logic             m_last;
    logic [ST_W-1:0]  m_status;

    // mirror of the heap contents, indexed 1..heap_count
    rec_t        heap_model [1:MAX_ITEMS];
    int unsigned heap_count = 0;
    result_t     expected_extractions [$];
    result_t     head_result;

    int       fail_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       gaps_enabled = 1'b1;
    rx_mode_t rx_mode = RX_CHOPPY;
    int       rx_run = 0;

    binary_max_heap_sort_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_position    (m_position),
        .m_last        (m_last),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_extractions.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Updates the heap mirror for one accepted transaction and queues the
    // result it should produce, if any.
    function automatic void predict_heap_op(input logic act, input logic [KEY_W-1:0] k,
                                            input logic [PAY_W-1:0] p);
        result_t     res;
        rec_t        top;
        rec_t        tmp;
        int unsigned j;
        int unsigned l;
        int unsigned r;
        int unsigned c;
        res = '0;
        if (act == ACT_LOAD) begin
            if (heap_count >= MAX_ITEMS) begin
                res.status = ST_FULL;
                expected_extractions.push_back(res);
            end else begin
                heap_count++;
                heap_model[heap_count].key = k;
                heap_model[heap_count].payload = p;
                // only a strictly greater key rises
                j = heap_count;
                while (j > 1 && heap_model[j].key > heap_model[j / 2].key) begin
                    tmp = heap_model[j];
                    heap_model[j] = heap_model[j / 2];
                    heap_model[j / 2] = tmp;
                    j = j / 2;
                end
            end
        end else if (heap_count == 0) begin
            res.status = ST_EMPTY;
            expected_extractions.push_back(res);
        end else begin
            top = heap_model[1];
            heap_model[1] = heap_model[heap_count];
            heap_count--;
            j = 1;
            while (2 * j < heap_count) begin
                l = 2 * j;
                r = l + 1;
                if (heap_model[j].key < heap_model[l].key ||
                    heap_model[j].key < heap_model[r].key) begin
                    c = (heap_model[r].key > heap_model[l].key) ? r : l;
                    tmp = heap_model[j];
                    heap_model[j] = heap_model[c];
                    heap_model[c] = tmp;
                    j = c;
                end else begin
                    break;
                end
            end
            // lone left child at the bottom
            if (2 * j == heap_count && heap_model[j].key < heap_model[2 * j].key) begin
                tmp = heap_model[j];
                heap_model[j] = heap_model[2 * j];
                heap_model[2 * j] = tmp;
            end
            res.key = top.key;
            res.payload = top.payload;
            res.position = POS_W'(heap_count);
            res.last = (heap_count == 0);
            res.status = ST_OK;
            expected_extractions.push_back(res);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_extractions.size() == 0) begin
                $display({"%0t: unexpected result, expected none, got key %0h ",
                          "payload %0h pos %0d last %0b status %0d"},
                         $time, m_out_key, m_out_payload, m_position, m_last, m_status);
                fail_count++;
            end else begin
                head_result = expected_extractions.pop_front();
                compare_field("out_key", head_result.key, m_out_key);
                compare_field("out_payload", head_result.payload, m_out_payload);
                compare_field("position", head_result.position, m_position);
                compare_field("last", head_result.last, m_last);
                compare_field("status", head_result.status, m_status);
            end
        end
    end

    // receiver back-pressure: alternating runs of ready and stall, or ready held high in RX_ALWAYS
    always @(negedge aclk) begin
        if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else if (rx_mode == RX_ALWAYS) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= !m_ready;
            rx_run <= m_ready ? $urandom_range(0, (rx_mode == RX_SLOW) ? 20 : 2)
                              : $urandom_range(0, 6);
        end
    end

    // Called and returns at a falling edge; valid stays high between
    // back-to-back transactions within a burst.
    task automatic send_heap_op(input logic act, input logic [KEY_W-1:0] k,
                                input logic [PAY_W-1:0] p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (gaps_enabled)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 32)
                                                  : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid = 1'b1;
        s_action = act;
        s_key = k;
        s_payload = p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_heap_op(act, k, p);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid = 1'b0;
        burst_left = 0;
        while (expected_extractions.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input key_style_t style);
        case (style)
            KEYS_NARROW: pick_key = KEY_W'($urandom_range(0, 7));
            KEYS_EDGE: begin
                case ($urandom_range(0, 3))
                    0: pick_key = '0;
                    1: pick_key = '1;
                    2: pick_key = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                    default: pick_key = ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
                endcase
            end
            default: pick_key = KEY_W'($urandom());
        endcase
    endfunction

    task automatic test_empty_and_extremes();
        send_heap_op(ACT_EXTRACT, '1, '1);
        send_heap_op(ACT_LOAD, '1, '1);
        send_heap_op(ACT_LOAD, '0, '0);
        send_heap_op(ACT_EXTRACT, '0, '0);
        send_heap_op(ACT_EXTRACT, '0, '0);
        send_heap_op(ACT_EXTRACT, '0, '0);
    endtask

    // equal keys: no rise on load, left child preferred on extract
    task automatic test_equal_keys();
        for (int i = 1; i <= 5; i++)
            send_heap_op(ACT_LOAD, KEY_W'(100), PAY_W'(i));
        repeat (5) send_heap_op(ACT_EXTRACT, '0, '0);
    endtask

    task automatic test_lone_left_child();
        send_heap_op(ACT_LOAD, KEY_W'(3), 32'h0000_0003);
        send_heap_op(ACT_LOAD, KEY_W'(2), 32'h0000_0002);
        send_heap_op(ACT_LOAD, KEY_W'(1), 32'h0000_0001);
        repeat (3) send_heap_op(ACT_EXTRACT, '0, '0);
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         seg_len;
        int         load_pct;
        key_style_t style;
        logic       act;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
                0: load_pct = 85;
                1: load_pct = 20;
                default: load_pct = 50;
            endcase
            style = key_style_t'($urandom_range(0, 2));
            gaps_enabled = ($urandom_range(0, 3) != 0);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            for (int i = 0; i < seg_len; i++) begin
                act = ($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_EXTRACT;
                send_heap_op(act, pick_key(style), $urandom());
            end
            sent += seg_len;
            if ($urandom_range(0, 4) == 0)
                wait_drain();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_LOAD;
        s_key = '0;
        s_payload = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_and_extremes();
        test_equal_keys();
        test_lone_left_child();
        wait_drain();
        test_random_traffic();
        wait_drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
